// File: design/assert_macros.svh
// Assertion helpers used by the datapath; sampled on i_clk, quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/utdb_pkg.sv
`default_nettype none

package utdb_pkg;

    localparam int unsigned CNT_W    = 6;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned IDX_W    = 11;
    localparam int unsigned TOG_DEPTH = 2048;

    localparam logic [LEN_W-1:0] MAX_BYTES         = 11'd512;
    localparam logic [LEN_W-1:0] FULL_SPEED_PACKET = 11'd64;
    localparam logic [LEN_W-1:0] LOW_SPEED_PACKET  = 11'd8;
    localparam int unsigned      MAX_RESULTS       = 64;
    localparam logic [CNT_W-1:0] LAST_CNT          = CNT_W'(MAX_RESULTS - 1);

    localparam logic [1:0] OP_SETUP = 2'd0;
    localparam logic [1:0] OP_IN    = 2'd1;
    localparam logic [1:0] OP_OUT   = 2'd2;

    localparam logic [7:0] PID_SETUP  = 8'h2D;
    localparam logic [7:0] PID_IN     = 8'h69;
    localparam logic [7:0] PID_OUT    = 8'hE1;
    localparam logic [7:0] STATUS_ACT = 8'h80;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 96;

    typedef struct packed {
        logic clear;
        logic load;
        logic emit;
        logic emit_err;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_too_long;
        logic pkt_last;
        logic slot_free;
    } t_dp_sts;

    function automatic logic [7:0] pid_code(input logic [1:0] op);
        logic [7:0] pid;
        case (op)
            OP_SETUP: pid = PID_SETUP;
            OP_IN:    pid = PID_IN;
            OP_OUT:   pid = PID_OUT;
            default:  pid = 8'h00;
        endcase
        return pid;
    endfunction

endpackage

`default_nettype wire

// File: design/utdb_ctrl.sv
`default_nettype none

module utdb_ctrl import utdb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_GEN,
        S_ERR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_too_long ? S_ERR : S_GEN;
                end
            end
            S_GEN: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.pkt_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: design/utdb_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module utdb_datapath import utdb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [IN_DATA_W-1:0]  i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_DATA_W-1:0]      o_data,
    output logic                       o_last,
    output logic                       o_user
);

    // request fields as packed on the input stream
    logic              in_bp;
    logic [LEN_W-1:0]  in_count;
    logic [31:0]       in_addr;
    logic [6:0]        in_dev;
    logic [3:0]        in_ep;
    logic              in_ls;

    assign in_bp    = i_data[0];
    assign in_count = i_data[11:1];
    assign in_addr  = i_data[43:12];
    assign in_dev   = i_data[50:44];
    assign in_ep    = i_data[54:51];
    assign in_ls    = i_data[55];

    // stage registers
    logic [1:0]       r_op;
    logic             r_bp;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_off;
    logic [31:0]      r_addr;
    logic [6:0]       r_dev;
    logic [3:0]       r_ep;
    logic             r_ls;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic             r_first;
    logic             r_tog_inv;

    // toggle store
    logic             r_tog_mem [TOG_DEPTH];
    logic             r_mem_q;
    logic [IDX_W-1:0] r_clr_addr;

    // output register
    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic                  r_olast;
    logic                  r_ouser;

    logic [LEN_W-1:0] maxlen;
    logic [LEN_W-1:0] pkt_len;
    logic             pkt_last;
    logic             tog_used;
    logic [3:0]       endp;
    logic [31:0]      ctrl_word;
    logic [31:0]      token_word;
    logic [31:0]      buf_ptr;
    logic             slot_free;
    logic             use_store;

    assign maxlen    = r_ls ? LOW_SPEED_PACKET : FULL_SPEED_PACKET;
    assign pkt_len   = (r_rem > maxlen) ? (maxlen - 1'b1) : (r_rem - 1'b1);
    assign pkt_last  = (r_rem <= maxlen) || (r_cnt == LAST_CNT);
    assign use_store = r_bp || (r_ep != 4'd0);

    always_comb begin
        if (r_op == OP_SETUP) begin
            tog_used = 1'b0;
            endp     = 4'd0;
        end else if (use_store) begin
            tog_used = r_first ? r_mem_q : r_tog_inv;
            endp     = r_ep;
        end else begin
            tog_used = 1'b1;
            endp     = 4'd0;
        end
    end

    assign ctrl_word  = {3'b000, 2'b11, r_ls, 1'b0, ~r_bp, STATUS_ACT, 16'h0000};
    assign token_word = {pkt_len, 1'b0, tog_used, endp, r_dev, pid_code(r_op)};
    assign buf_ptr    = r_bp ? (r_addr + {{(32-LEN_W){1'b0}}, r_off}) : 32'd0;

    assign slot_free = !r_ovalid || i_ready;

    assign o_sts.clr_done    = (r_clr_addr == IDX_W'(TOG_DEPTH - 1));
    assign o_sts.in_too_long = (in_count > MAX_BYTES);
    assign o_sts.pkt_last    = pkt_last;
    assign o_sts.slot_free   = slot_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_opcode;
            r_bp      <= in_bp;
            r_rem     <= in_count;
            r_off     <= '0;
            r_addr    <= in_addr;
            r_dev     <= in_dev;
            r_ep      <= in_ep;
            r_ls      <= in_ls;
            r_idx     <= {in_dev, in_ep};
            r_cnt     <= '0;
            r_first   <= 1'b1;
            r_tog_inv <= 1'b0;
        end else if (i_cmd.emit) begin
            // advance to the next packet of the stage
            if (r_rem < maxlen) begin
                r_rem <= '0;
            end else begin
                r_rem <= r_rem - maxlen;
                r_off <= r_off + maxlen;
            end
            r_cnt     <= r_cnt + 1'b1;
            r_first   <= 1'b0;
            r_tog_inv <= ~tog_used;
        end
    end

    // toggle store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_tog_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.emit && pkt_last) begin
            r_tog_mem[r_idx] <= ~tog_used;
        end
        if (i_cmd.load) begin
            r_mem_q <= r_tog_mem[{in_dev, in_ep}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !o_sts.clr_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= {buf_ptr, token_word, ctrl_word};
            r_olast <= pkt_last;
            r_ouser <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_odata <= '0;
            r_olast <= 1'b0;
            r_ouser <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
    assign o_user  = r_ouser;

    `ASSERT_NOW(a_emit_needs_slot, i_cmd.emit || i_cmd.emit_err, slot_free)
    `ASSERT_NOW(a_single_emit, i_cmd.emit, !i_cmd.emit_err && !i_cmd.load && !i_cmd.clear)
    `ASSERT_NOW(a_err_result_empty, r_ovalid && r_ouser, (r_odata == '0) && !r_olast)
    `ASSERT_NEXT(a_first_clear, i_cmd.load, r_first && (r_cnt == '0))

endmodule

`default_nettype wire

// File: design/usb_transfer_descriptor_builder_unit.sv
`default_nettype none

// USB transfer descriptor builder.
// Slave stream carries one request per transfer stage; tuser holds the packet id
// kind, tdata the buffer flag, byte count, buffer address, device, endpoint and
// speed. The master stream returns one descriptor word set per packet: control
// word, token word and buffer pointer in tdata, tlast on the final packet of the
// stage, tuser high on the single result of a request whose count is too large.
// After reset the per-endpoint toggle store is swept to zero, one entry a cycle:
// tready stays low until the sweep ends. Then a request is taken when the block
// is idle and loaded into the stage registers; its descriptors are registered
// in the output register, one per cycle from a single packet generator, and a
// stage of 1 to 64 packets ends before the next request is taken.
// A stalled receiver holds the output register and freezes the generator; the
// final descriptor may still wait in the output register while the next request
// is accepted. The toggle store is read once when a request is accepted and
// written once, as the final packet is emitted (not for a too-large count).
module usb_transfer_descriptor_builder_unit import utdb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [0] buffer_present, [11:1] byte_count, [43:12] buffer_addr,
    // [50:44] device_addr, [54:51] endpoint_num, [55] low_speed
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [31:0] control_word, [63:32] token_word, [95:64] buffer_pointer
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                       o_m_axis_tlast,
    // [0] length_error
    output logic                       o_m_axis_tuser
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence the clearing sweep, request intake and packet emission
    utdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // hold the stage, toggle store and output register
    utdb_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_opcode (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast),
        .o_user   (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: test/descriptor_checker.sv
`default_nettype none

// Watches both streams of the descriptor builder, predicts the descriptor
// sets of each accepted request and compares them in order.
module descriptor_checker import utdb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // [0] buffer_present, [11:1] byte_count, [43:12] buffer_addr,
    // [50:44] device_addr, [54:51] endpoint_num, [55] low_speed
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]            i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // [31:0] control_word, [63:32] token_word, [95:64] buffer_pointer
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                  i_m_tlast,
    // [0] length_error
    input  wire logic                  i_m_tuser,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_stage_count,
    output int                         o_desc_count,
    output int                         o_oversize_count
);

    typedef struct packed {
        logic [31:0] control;
        logic [31:0] token;
        logic [31:0] pointer;
        logic        last;
        logic        oversize;
    } t_descriptor;

    t_descriptor expected_q[$];
    logic        toggle_store [TOG_DEPTH];

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            o_fail_count++;
        end
    endtask

    // Cut one stage into packets and queue the descriptor of each.
    task automatic predict_descriptors(input logic [1:0] op,
                                       input logic [IN_DATA_W-1:0] req);
        logic              bp, ls, tog, last;
        logic [LEN_W-1:0]  count, pkt, len, remaining;
        logic [31:0]       addr, offset, ctrl;
        logic [6:0]        dev;
        logic [3:0]        ep, endp;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        pid;
        int                emitted;
        t_descriptor       d;

        {ls, ep, dev, addr, count, bp} = req;
        idx = {dev, ep};
        o_stage_count++;

        if (count > MAX_BYTES) begin
            d          = '0;
            d.oversize = 1'b1;
            expected_q.push_back(d);
            o_oversize_count++;
            return;
        end

        case (op)
            OP_SETUP: pid = PID_SETUP;
            OP_IN:    pid = PID_IN;
            OP_OUT:   pid = PID_OUT;
            default:  pid = 8'h00;
        endcase

        pkt       = ls ? LOW_SPEED_PACKET : FULL_SPEED_PACKET;
        ctrl      = {3'b000, 2'b11, ls, 1'b0, ~bp, STATUS_ACT, 16'h0000};
        remaining = count;
        offset    = '0;
        emitted   = 0;

        do begin
            if (op == OP_SETUP) begin
                endp = '0;
                tog  = 1'b0;
            end else if (bp || ep != 4'd0) begin
                endp = ep;
                tog  = toggle_store[idx];
            end else begin
                endp = '0;
                tog  = 1'b1;
            end
            toggle_store[idx] = ~tog;

            // zero remaining wraps to all ones in the length field
            len = (remaining > pkt) ? pkt - 11'd1 : remaining - 11'd1;

            d.control  = ctrl;
            d.token    = {len, 1'b0, tog, endp, dev, pid};
            d.pointer  = bp ? addr + offset : 32'h0;
            d.oversize = 1'b0;

            if (remaining < pkt) begin
                remaining = '0;
            end else begin
                remaining = remaining - pkt;
                offset    = offset + 32'(pkt);
            end
            last   = (remaining == '0) || (emitted + 1 >= MAX_RESULTS);
            d.last = last;
            expected_q.push_back(d);
            emitted++;
        end while (!last);
    endtask

    always @(posedge i_clk) begin
        t_descriptor want;
        if (!i_rst_n) begin
            foreach (toggle_store[i]) toggle_store[i] = 1'b0;
            expected_q.delete();
            o_fail_count     = 0;
            o_stage_count    = 0;
            o_desc_count     = 0;
            o_oversize_count = 0;
        end else begin
            // a result never belongs to a request accepted at the same edge
            if (i_m_tvalid && i_m_tready) begin
                o_desc_count++;
                if (expected_q.size() == 0) begin
                    $error("descriptor with nothing expected: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("control_word", want.control, i_m_tdata[31:0]);
                    check_field("token_word", want.token, i_m_tdata[63:32]);
                    check_field("buffer_pointer", want.pointer, i_m_tdata[95:64]);
                    check_field("last_packet", 32'(want.last), 32'(i_m_tlast));
                    check_field("length_error", 32'(want.oversize), 32'(i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_descriptors(i_s_tuser, i_s_tdata);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

// Stimulus and verdict for the descriptor builder. The checker beside the
// block does all prediction and comparison; this module only drives the
// request stream, paces the descriptor stream and decides the outcome.
module testbench import utdb_pkg::*; ();

    localparam int         HALF_PERIOD     = 6;
    localparam int         RESET_CYCLES    = 6;
    // Covers the toggle sweep after reset and the long hold-off.
    localparam int         WATCHDOG_LIMIT  = 20000;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         PHASE_REQUESTS  = 29;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int   fail_count, pending, stage_count, desc_count, oversize_count;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;
    logic hold_req       = 1'b0;
    logic hold_ack       = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    usb_transfer_descriptor_builder_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    descriptor_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tuser        (s_tuser),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tlast        (m_tlast),
        .i_m_tuser        (m_tuser),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_stage_count    (stage_count),
        .o_desc_count     (desc_count),
        .o_oversize_count (oversize_count)
    );

    // Offer one stage request, after a random gap, and hold it until taken.
    // Leave tvalid high on return: the caller either offers the next request
    // at this same falling edge or lowers tvalid itself.
    task automatic send_stage(input logic [1:0] op, input logic bp,
                              input logic [10:0] count, input logic [31:0] addr,
                              input logic [6:0] dev, input logic [3:0] ep,
                              input logic ls);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ls, ep, dev, addr, count, bp};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Mostly well-formed stages on a few busy endpoints so the toggles get
    // reused; the rest spread over every device, endpoint and oversize count.
    task automatic send_random_stage();
        logic [1:0]  op;
        logic [10:0] count;
        logic [6:0]  dev;
        logic [3:0]  ep;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            count = 11'($urandom_range(130));
        end else if (pick < 70) begin
            count = 11'($urandom_range(512, 131));
        end else if (pick < 82) begin
            case ($urandom_range(3))
                0:       count = 11'd0;
                1:       count = LOW_SPEED_PACKET;
                2:       count = FULL_SPEED_PACKET;
                default: count = MAX_BYTES;
            endcase
        end else begin
            count = 11'($urandom_range(2047, 513));
        end
        op = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
        if ($urandom_range(9) < 7) begin
            dev = 7'($urandom_range(3));
            ep  = 4'($urandom_range(3));
        end else begin
            dev = 7'($urandom);
            ep  = 4'($urandom);
        end
        send_stage(op, $urandom_range(99) < 85, count, $urandom, dev, ep,
                   $urandom_range(9) < 3);
    endtask

    // Drop tvalid and hold until every predicted descriptor has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Receiver: random stalls at the current rate, or one long hold-off when
    // the stimulus flips hold_req; the stretch is counted here.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end else begin
                m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Abort when neither stream moves for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int send_pcts [4] = '{0, 59, 0, 19};
        int recv_pcts [4] = '{0, 0, 59, 19};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests, no idling on either side.
        // SETUP on endpoint 0, then IN of exactly one full packet
        send_stage(OP_SETUP,  1'b1, 11'd8,    32'h0000_1000, 7'd0,   4'd0,  1'b0);
        send_stage(OP_IN,     1'b1, 11'd64,   32'h0000_2000, 7'd0,   4'd0,  1'b0);
        // zero-length status stage on endpoint 0 without a buffer
        send_stage(OP_OUT,    1'b0, 11'd0,    32'h0000_0000, 7'd0,   4'd0,  1'b0);
        // SETUP aimed at a non-zero endpoint: endpoint field forced to zero
        send_stage(OP_SETUP,  1'b1, 11'd8,    32'hFFFF_FFFF, 7'd127, 4'd5,  1'b1);
        send_stage(OP_IN,     1'b1, 11'd16,   32'h0000_0000, 7'd127, 4'd5,  1'b1);
        // zero length with a buffer
        send_stage(OP_IN,     1'b1, 11'd0,    32'h1234_5678, 7'd3,   4'd0,  1'b0);
        // largest legal stage at full speed, pointer wraps past the top
        send_stage(OP_OUT,    1'b1, 11'd512,  32'hFFFF_FFC0, 7'd1,   4'd1,  1'b0);
        // largest legal stage at low speed: the full 64 descriptors
        send_stage(OP_IN,     1'b1, 11'd512,  32'h8000_0000, 7'd127, 4'd15, 1'b1);
        // oversize counts: just over the limit and all ones
        send_stage(OP_OUT,    1'b1, 11'd513,  32'h0000_4000, 7'd9,   4'd2,  1'b0);
        send_stage(OP_IN,     1'b1, 11'd2047, 32'hFFFF_FFFF, 7'd127, 4'd15, 1'b1);
        // either side of a packet boundary
        send_stage(OP_OUT,    1'b1, 11'd65,   32'h0000_0100, 7'd2,   4'd3,  1'b0);
        send_stage(OP_OUT,    1'b1, 11'd63,   32'h0000_0100, 7'd2,   4'd3,  1'b0);
        send_stage(OP_IN,     1'b1, 11'd7,    32'h0000_0010, 7'd4,   4'd1,  1'b1);
        send_stage(OP_IN,     1'b1, 11'd9,    32'h0000_0010, 7'd4,   4'd1,  1'b1);
        // unused opcode: no pid, toggle handled as for IN and OUT
        send_stage(OP_UNUSED, 1'b1, 11'd20,   32'hA5A5_A5A5, 7'd6,   4'd7,  1'b0);
        send_stage(OP_UNUSED, 1'b0, 11'd0,    32'h0000_0000, 7'd6,   4'd0,  1'b0);
        // no buffer yet a non-zero count: split by count, null pointers
        send_stage(OP_OUT,    1'b0, 11'd100,  32'hDEAD_BEEF, 7'd5,   4'd0,  1'b0);
        send_stage(OP_IN,     1'b0, 11'd10,   32'h0000_0000, 7'd5,   4'd9,  1'b1);
        // back to back on one endpoint to see the toggle flip
        send_stage(OP_IN,     1'b1, 11'd1,    32'h5555_5555, 7'd127, 4'd15, 1'b0);
        send_stage(OP_IN,     1'b1, 11'd1,    32'hAAAA_AAAA, 7'd127, 4'd15, 1'b0);
        send_stage(OP_OUT,    1'b1, 11'd512,  32'h0000_0000, 7'd0,   4'd0,  1'b1);
        drain();

        // Long receiver hold-off while requests keep coming, so the block
        // backs up and drops tready; then pause until all is returned.
        hold_req <= ~hold_req;
        repeat (12) send_random_stage();
        drain();

        // Random requests through each idling pattern in turn.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            repeat (PHASE_REQUESTS) send_random_stage();
        end
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("testbench: %0d stage requests, %0d descriptors checked, %0d oversize",
                 stage_count, desc_count, oversize_count);
        $display("testbench: idling none/sender/receiver/both, one %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
